### rtl/sts_pkg.sv
// sts_pkg: shared types and constants for the S-expression token scanner.
// Used by sexpr_token_scanner and its port checker; no dependencies.
package sts_pkg;

  // Default width of the byte, line and column counters.
  localparam int unsigned POSITION_BITS_DEF = 24;

  // Fixed result field widths.
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned COORD_W  = 25;
  localparam int unsigned BYTE_W   = 8;

  // Result queue depth; one item can push two entries.
  localparam int unsigned RES_DEPTH = 4;

  // Byte codes.
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;

  // Register reset values.
  localparam logic [BYTE_W-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;

  typedef enum logic [1:0] {
    CFG_COMMENT_CHAR = 2'd0,
    CFG_OPEN_CHAR    = 2'd1,
    CFG_CLOSE_CHAR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_END    = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_WORD   = 3'd3,
    KIND_NUMBER = 3'd4,
    KIND_STRING = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_COMMENT    = 3'd1,
    MODE_WORD       = 3'd2,
    MODE_NUMBER     = 3'd3,
    MODE_STRING     = 3'd4,
    MODE_STRING_ESC = 3'd5
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] length;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
    logic                last;
  } res_t;

endpackage

### rtl/sexpr_token_scanner.sv
// sexpr_token_scanner: byte-serial S-expression lexer with a result queue.
// Depends on sts_pkg.
//
// One source byte (or an end-of-input marker) is taken per beat, and a new
// beat can be taken every clock cycle while in_stall_o is low. Each beat is
// scanned in the cycle it is accepted: the scan state and position counters
// update at that edge, and the zero, one or two token descriptors it causes
// are written into a four-entry result queue, which drives the output channel
// one descriptor per cycle while out_stall_i is low. in_stall_o rises while
// fewer than two queue slots are free, so the input runs at one byte per cycle
// for as long as the consumer keeps pace with one result per byte; bursts of
// two-result bytes (a word ended by a parenthesis, a flush at end of input)
// are absorbed by the queue. Counters for offset, line and line start are
// POSITION_BITS wide and saturate. The user must write the three character
// registers through the cfg port only while idle; the block does not enforce it.
module sexpr_token_scanner #(
  parameter int unsigned POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [sts_pkg::BYTE_W-1:0]   cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sts_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                         end_of_input_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   token_kind_o,
  output logic [sts_pkg::OFFSET_W-1:0] start_offset_o,
  output logic [sts_pkg::OFFSET_W-1:0] token_length_o,
  output logic [sts_pkg::COORD_W-1:0]  start_row_o,
  output logic [sts_pkg::COORD_W-1:0]  start_column_o,
  output logic                         last_of_run_o
);

  localparam int unsigned P     = POSITION_BITS;
  localparam int unsigned DEPTH = sts_pkg::RES_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------- config
  logic [sts_pkg::BYTE_W-1:0] comment_q, open_q, close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= sts_pkg::CH_SEMICOLON;
      open_q    <= sts_pkg::CH_LPAREN;
      close_q   <= sts_pkg::CH_RPAREN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sts_pkg::CFG_COMMENT_CHAR: comment_q <= cfg_data_i;
        sts_pkg::CFG_OPEN_CHAR:    open_q    <= cfg_data_i;
        sts_pkg::CFG_CLOSE_CHAR:   close_q   <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- scan state
  sts_pkg::mode_e mode_q, mode_d;
  logic [P-1:0] begin_q, begin_d;       // token start offset
  logic [P-1:0] begin_row_q, begin_row_d;
  logic [P-1:0] begin_col_q, begin_col_d;
  logic [P-1:0] pos_q, pos_d;           // byte offset
  logic [P-1:0] line_q, line_d;         // 0-based line
  logic [P-1:0] line_begin_q, line_begin_d;

  logic accept;
  logic [sts_pkg::BYTE_W-1:0] b;
  logic is_nl, is_blank, is_comment, is_open, is_close, is_digit, ends_word;
  logic run_idle;   // byte falls through to between-token handling

  logic [P-1:0] pos_inc, line_inc, column0, pend_len, close_len;
  logic [P:0]   line_p1, begin_row_p1, begin_col_p1, column_p1;

  assign accept = in_valid_i && !in_stall_o;
  assign b      = text_byte_i;

  assign is_nl      = (b == sts_pkg::CH_NEWLINE);
  assign is_blank   = (b == sts_pkg::CH_SPACE) ||
                      ((b >= sts_pkg::CH_TAB) && (b <= sts_pkg::CH_CR));
  assign is_comment = (b == comment_q);
  assign is_open    = (b == open_q);
  assign is_close   = (b == close_q);
  assign is_digit   = (b >= sts_pkg::CH_ZERO) && (b <= sts_pkg::CH_NINE);
  assign ends_word  = is_blank || is_comment || is_open || is_close;

  // saturating increments
  assign pos_inc  = (pos_q == {P{1'b1}})  ? pos_q  : pos_q + P'(1);
  assign line_inc = (line_q == {P{1'b1}}) ? line_q : line_q + P'(1);

  assign column0   = (line_begin_q > pos_q) ? '0 : pos_q - line_begin_q;
  assign pend_len  = (begin_q > pos_q)   ? '0 : pos_q - begin_q;
  assign close_len = (begin_q > pos_inc) ? '0 : pos_inc - begin_q;

  // 1-based coordinates, one bit wider before trimming to the field
  assign line_p1      = {1'b0, line_q}      + (P+1)'(1);
  assign column_p1    = {1'b0, column0}     + (P+1)'(1);
  assign begin_row_p1 = {1'b0, begin_row_q} + (P+1)'(1);
  assign begin_col_p1 = {1'b0, begin_col_q} + (P+1)'(1);

  // decode: does this byte go through the between-token path
  always_comb begin
    run_idle = 1'b0;
    unique case (mode_q)
      sts_pkg::MODE_COMMENT:                           run_idle = is_nl;
      sts_pkg::MODE_WORD, sts_pkg::MODE_NUMBER:        run_idle = ends_word;
      sts_pkg::MODE_STRING, sts_pkg::MODE_STRING_ESC:  run_idle = is_nl;
      default:                                         run_idle = 1'b1;
    endcase
  end

  // next scan mode
  always_comb begin
    mode_d = mode_q;
    if (end_of_input_i) begin
      mode_d = sts_pkg::MODE_IDLE;
    end else if (run_idle) begin
      if (is_blank) begin
        mode_d = sts_pkg::MODE_IDLE;
      end else if (is_comment) begin
        mode_d = sts_pkg::MODE_COMMENT;
      end else if (is_open || is_close) begin
        mode_d = sts_pkg::MODE_IDLE;
      end else if (b == sts_pkg::CH_QUOTE) begin
        mode_d = sts_pkg::MODE_STRING;
      end else if (is_digit) begin
        mode_d = sts_pkg::MODE_NUMBER;
      end else begin
        mode_d = sts_pkg::MODE_WORD;
      end
    end else begin
      unique case (mode_q)
        sts_pkg::MODE_STRING_ESC: mode_d = sts_pkg::MODE_STRING;
        sts_pkg::MODE_STRING: begin
          if (b == sts_pkg::CH_BACKSLASH) begin
            mode_d = sts_pkg::MODE_STRING_ESC;
          end else if (b == sts_pkg::CH_QUOTE) begin
            mode_d = sts_pkg::MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // counters and results
  sts_pkg::res_t res_a, res_b;   // a: token closed by this byte, b: token it emits
  logic          a_vld, b_vld;

  always_comb begin
    begin_d      = begin_q;
    begin_row_d  = begin_row_q;
    begin_col_d  = begin_col_q;
    pos_d        = pos_q;
    line_d       = line_q;
    line_begin_d = line_begin_q;
    a_vld        = 1'b0;
    b_vld        = 1'b0;

    // pending token as seen before this byte
    res_a.kind   = (mode_q == sts_pkg::MODE_WORD)   ? sts_pkg::KIND_WORD :
                   (mode_q == sts_pkg::MODE_NUMBER) ? sts_pkg::KIND_NUMBER :
                                                      sts_pkg::KIND_ERROR;
    res_a.offset = sts_pkg::OFFSET_W'(begin_q);
    res_a.length = sts_pkg::OFFSET_W'(pend_len);
    res_a.row    = sts_pkg::COORD_W'(begin_row_p1);
    res_a.column = sts_pkg::COORD_W'(begin_col_p1);
    res_a.last   = 1'b0;

    // single-byte token at the current position by default
    res_b.kind   = is_open ? sts_pkg::KIND_OPEN : sts_pkg::KIND_CLOSE;
    res_b.offset = sts_pkg::OFFSET_W'(pos_q);
    res_b.length = sts_pkg::OFFSET_W'(1);
    res_b.row    = sts_pkg::COORD_W'(line_p1);
    res_b.column = sts_pkg::COORD_W'(column_p1);
    res_b.last   = 1'b1;

    if (end_of_input_i) begin
      a_vld        = (mode_q == sts_pkg::MODE_WORD) || (mode_q == sts_pkg::MODE_NUMBER) ||
                     (mode_q == sts_pkg::MODE_STRING) ||
                     (mode_q == sts_pkg::MODE_STRING_ESC);
      b_vld        = 1'b1;
      res_b.kind   = sts_pkg::KIND_END;
      res_b.length = '0;
      begin_d      = '0;
      begin_row_d  = '0;
      begin_col_d  = '0;
      pos_d        = '0;
      line_d       = '0;
      line_begin_d = '0;
    end else begin
      pos_d = pos_inc;
      if (is_nl) begin
        line_d       = line_inc;
        line_begin_d = pos_inc;
      end
      // word end or string broken by newline
      a_vld = run_idle && (mode_q != sts_pkg::MODE_IDLE) &&
              (mode_q != sts_pkg::MODE_COMMENT) &&
              ((mode_q == sts_pkg::MODE_WORD) || (mode_q == sts_pkg::MODE_NUMBER) ||
               (mode_q == sts_pkg::MODE_STRING) ||
               (mode_q == sts_pkg::MODE_STRING_ESC));
      if (run_idle) begin
        if (!is_blank && !is_comment) begin
          if (is_open || is_close) begin
            b_vld = 1'b1;
          end else begin
            begin_d     = pos_q;
            begin_row_d = line_q;
            begin_col_d = column0;
          end
        end
      end else if ((mode_q == sts_pkg::MODE_STRING) && (b == sts_pkg::CH_QUOTE)) begin
        b_vld        = 1'b1;
        res_b.kind   = sts_pkg::KIND_STRING;
        res_b.offset = sts_pkg::OFFSET_W'(begin_q);
        res_b.length = sts_pkg::OFFSET_W'(close_len);
        res_b.row    = sts_pkg::COORD_W'(begin_row_p1);
        res_b.column = sts_pkg::COORD_W'(begin_col_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sts_pkg::MODE_IDLE;
      begin_q      <= '0;
      begin_row_q  <= '0;
      begin_col_q  <= '0;
      pos_q        <= '0;
      line_q       <= '0;
      line_begin_q <= '0;
    end else if (accept) begin
      mode_q       <= mode_d;
      begin_q      <= begin_d;
      begin_row_q  <= begin_row_d;
      begin_col_q  <= begin_col_d;
      pos_q        <= pos_d;
      line_q       <= line_d;
      line_begin_q <= line_begin_d;
    end
  end

  // ---------------------------------------------------------------- result queue
  sts_pkg::res_t ent0, ent1;
  logic [1:0]    n_push;
  logic          pop;

  sts_pkg::res_t res_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  // pack the closed token first, then the emitted one
  always_comb begin
    ent0 = a_vld ? res_a : res_b;
    ent1 = res_b;
    ent0.last = !(a_vld && b_vld);
    n_push = accept ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
  end

  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      res_q[wr_ptr_q] <= ent0;
    end
    if (n_push == 2'd2) begin
      res_q[wr_ptr_q + PTR_W'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  // room for two entries is needed before a beat is taken
  assign in_stall_o = (count_q > CNT_W'(DEPTH - 2));

  assign out_valid_o    = (count_q != '0);
  assign token_kind_o   = res_q[rd_ptr_q].kind;
  assign start_offset_o = res_q[rd_ptr_q].offset;
  assign token_length_o = res_q[rd_ptr_q].length;
  assign start_row_o    = res_q[rd_ptr_q].row;
  assign start_column_o = res_q[rd_ptr_q].column;
  assign last_of_run_o  = res_q[rd_ptr_q].last;

endmodule

### rtl/sts_checker.sv
// sts_checker: port-level assertions for sexpr_token_scanner, bound to it below.
// Depends on sts_pkg.
module sts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         end_of_input_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [2:0]                   token_kind_o,
  input logic [sts_pkg::OFFSET_W-1:0] start_offset_o,
  input logic [sts_pkg::OFFSET_W-1:0] token_length_o,
  input logic [sts_pkg::COORD_W-1:0]  start_row_o,
  input logic [sts_pkg::COORD_W-1:0]  start_column_o,
  input logic                         last_of_run_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(token_length_o) && $stable(start_row_o) &&
      $stable(start_column_o) && $stable(last_of_run_o))
    else $error("result beat changed while stalled");

  // end token is empty and closes its run
  a_end_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == sts_pkg::KIND_END) |->
      (token_length_o == '0) && last_of_run_o)
    else $error("malformed end token");

  // parenthesis tokens are one byte and always last of their run
  a_paren_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == sts_pkg::KIND_OPEN) ||
                    (token_kind_o == sts_pkg::KIND_CLOSE)) |->
      (token_length_o == sts_pkg::OFFSET_W'(1)) && last_of_run_o)
    else $error("malformed parenthesis token");

  // end of input always yields a result on the next cycle
  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_input_i |=> out_valid_o)
    else $error("no result after end of input");

endmodule

bind sexpr_token_scanner sts_checker u_sts_checker (.*);

### verif/sexpr_token_scanner_tb.sv
// sexpr_token_scanner_tb: self-checking bench for the S-expression token scanner.
// Depends on sts_pkg and sexpr_token_scanner. It feeds byte beats, tracks the lexer
// state in step with the DUT and checks every token descriptor on the result channel.
module sexpr_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned FLUSH_CYCLES = 8;     // margin after the owed descriptors drain
  localparam int unsigned DRAIN_LIMIT  = 5000;  // cycles to wait for outstanding tokens
  localparam int unsigned MIX_BEATS    = 50;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned POS_W        = sts_pkg::POSITION_BITS_DEF;
  localparam int unsigned BYTE_W       = sts_pkg::BYTE_W;
  localparam int unsigned OFFSET_W     = sts_pkg::OFFSET_W;
  localparam int unsigned COORD_W      = sts_pkg::COORD_W;

  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_SAT = '1;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [1:0]          cfg_index_i    = '0;
  logic [BYTE_W-1:0]   cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [BYTE_W-1:0]   text_byte_i    = '0;
  logic                end_of_input_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [2:0]          token_kind_o;
  logic [OFFSET_W-1:0] start_offset_o;
  logic [OFFSET_W-1:0] token_length_o;
  logic [COORD_W-1:0]  start_row_o;
  logic [COORD_W-1:0]  start_column_o;
  logic                last_of_run_o;

  always #CLK_HALF clk_i = ~clk_i;

  sexpr_token_scanner #(
    .POSITION_BITS(POS_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .start_row_o    (start_row_o),
    .start_column_o (start_column_o),
    .last_of_run_o  (last_of_run_o)
  );

  // ---------------------------------------------------------------------------
  // Lexer shadow: character registers, scan state and position counters.
  // Positions, rows and columns are kept 0-based; descriptors add one to rows and columns.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] cmt_ch   = sts_pkg::CH_SEMICOLON;
  logic [BYTE_W-1:0] open_ch  = sts_pkg::CH_LPAREN;
  logic [BYTE_W-1:0] close_ch = sts_pkg::CH_RPAREN;

  sts_pkg::mode_e lex_mode = sts_pkg::MODE_IDLE;
  pos_t  tok_start  = '0;
  pos_t  tok_row    = '0;
  pos_t  tok_col    = '0;
  pos_t  cur_pos    = '0;
  pos_t  cur_line   = '0;
  pos_t  line_start = '0;

  sts_pkg::res_t token_q[$];   // descriptors still owed by the DUT, oldest first

  // Run bookkeeping
  int unsigned fail_cnt      = 0;
  int unsigned bytes_fed     = 0;
  int unsigned streams_fed   = 0;
  int unsigned tokens_seen   = 0;
  int unsigned feed_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_off      = 1'b0;

  function automatic pos_t bump(pos_t v);
    return (v == POS_SAT) ? v : v + 1'b1;
  endfunction

  function automatic pos_t column_now();
    return (line_start > cur_pos) ? '0 : cur_pos - line_start;
  endfunction

  function automatic pos_t pending_len();
    return (tok_start > cur_pos) ? '0 : cur_pos - tok_start;
  endfunction

  function automatic bit is_blank(logic [BYTE_W-1:0] b);
    return b == sts_pkg::CH_SPACE || (b >= sts_pkg::CH_TAB && b <= sts_pkg::CH_CR);
  endfunction

  function automatic bit ends_word(logic [BYTE_W-1:0] b);
    return is_blank(b) || b == cmt_ch || b == open_ch || b == close_ch;
  endfunction

  function automatic void push_token(sts_pkg::kind_e kind, pos_t start, pos_t len,
                                     pos_t row0, pos_t col0);
    sts_pkg::res_t t;
    t.kind   = kind;
    t.offset = OFFSET_W'(start);
    t.length = OFFSET_W'(len);
    t.row    = COORD_W'(row0) + 1'b1;
    t.column = COORD_W'(col0) + 1'b1;
    t.last   = 1'b0;
    token_q.push_back(t);
  endfunction

  // Counts one byte; a newline opens a new line at the next offset.
  function automatic void step_over(logic [BYTE_W-1:0] b);
    if (b == sts_pkg::CH_NEWLINE) begin
      cur_line   = bump(cur_line);
      line_start = bump(cur_pos);
    end
    cur_pos = bump(cur_pos);
  endfunction

  function automatic void flush_word();
    push_token((lex_mode == sts_pkg::MODE_WORD) ? sts_pkg::KIND_WORD
                                                 : sts_pkg::KIND_NUMBER,
               tok_start, pending_len(), tok_row, tok_col);
  endfunction

  // Between tokens: blank, comment char, parens, quote, digit, in that priority.
  function automatic void scan_idle(logic [BYTE_W-1:0] b);
    lex_mode = sts_pkg::MODE_IDLE;
    if (is_blank(b)) begin
    end else if (b == cmt_ch) begin
      lex_mode = sts_pkg::MODE_COMMENT;
    end else if (b == open_ch || b == close_ch) begin
      push_token((b == open_ch) ? sts_pkg::KIND_OPEN : sts_pkg::KIND_CLOSE, cur_pos,
                 pos_t'(1), cur_line, column_now());
    end else begin
      tok_start = cur_pos;
      tok_row   = cur_line;
      tok_col   = column_now();
      if (b == sts_pkg::CH_QUOTE) begin
        lex_mode = sts_pkg::MODE_STRING;
      end else if (b >= sts_pkg::CH_ZERO && b <= sts_pkg::CH_NINE) begin
        lex_mode = sts_pkg::MODE_NUMBER;
      end else begin
        lex_mode = sts_pkg::MODE_WORD;
      end
    end
    step_over(b);
  endfunction

  // Works out the descriptors one accepted beat causes and queues them.
  function automatic void predict_tokens(logic [BYTE_W-1:0] b, logic eoi);
    int unsigned   queued;
    sts_pkg::res_t t;
    queued = token_q.size();
    if (eoi) begin
      if (lex_mode == sts_pkg::MODE_WORD || lex_mode == sts_pkg::MODE_NUMBER) begin
        flush_word();
      end else if (lex_mode == sts_pkg::MODE_STRING ||
                   lex_mode == sts_pkg::MODE_STRING_ESC) begin
        push_token(sts_pkg::KIND_ERROR, tok_start, pending_len(), tok_row, tok_col);
      end
      push_token(sts_pkg::KIND_END, cur_pos, '0, cur_line, column_now());
      // next byte opens a fresh stream at row 1, column 1
      lex_mode   = sts_pkg::MODE_IDLE;
      tok_start  = '0;
      tok_row    = '0;
      tok_col    = '0;
      cur_pos    = '0;
      cur_line   = '0;
      line_start = '0;
    end else begin
      case (lex_mode)
        sts_pkg::MODE_COMMENT: begin
          if (b == sts_pkg::CH_NEWLINE) scan_idle(b);
          else step_over(b);
        end
        sts_pkg::MODE_WORD, sts_pkg::MODE_NUMBER: begin
          if (ends_word(b)) begin
            flush_word();
            scan_idle(b);   // the ending byte may itself be a paren token
          end else begin
            step_over(b);
          end
        end
        sts_pkg::MODE_STRING, sts_pkg::MODE_STRING_ESC: begin
          if (b == sts_pkg::CH_NEWLINE) begin
            // unclosed string, even right after a backslash
            push_token(sts_pkg::KIND_ERROR, tok_start, pending_len(), tok_row, tok_col);
            scan_idle(b);
          end else if (lex_mode == sts_pkg::MODE_STRING_ESC) begin
            lex_mode = sts_pkg::MODE_STRING;
            step_over(b);
          end else if (b == sts_pkg::CH_BACKSLASH) begin
            lex_mode = sts_pkg::MODE_STRING_ESC;
            step_over(b);
          end else if (b == sts_pkg::CH_QUOTE) begin
            step_over(b);
            push_token(sts_pkg::KIND_STRING, tok_start, pending_len(), tok_row, tok_col);
            lex_mode = sts_pkg::MODE_IDLE;
          end else begin
            step_over(b);
          end
        end
        default: scan_idle(b);
      endcase
    end
    if (token_q.size() > queued) begin
      t      = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endfunction

  function automatic void apply_char(logic [1:0] idx, logic [BYTE_W-1:0] val);
    case (sts_pkg::cfg_idx_e'(idx))
      sts_pkg::CFG_COMMENT_CHAR: cmt_ch   = val;
      sts_pkg::CFG_OPEN_CHAR:    open_ch  = val;
      sts_pkg::CFG_CLOSE_CHAR:   close_ch = val;
      default: ;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_token();
    sts_pkg::res_t want;
    tokens_seen++;
    if (token_q.size() == 0) begin
      note_failure($sformatf("unexpected descriptor kind %0d off %0d len %0d",
                             token_kind_o, start_offset_o, token_length_o));
      return;
    end
    want = token_q.pop_front();
    if (token_kind_o !== want.kind || start_offset_o !== want.offset ||
        token_length_o !== want.length || start_row_o !== want.row ||
        start_column_o !== want.column || last_of_run_o !== want.last) begin
      note_failure($sformatf(
        "token %0d expected %s off %0d len %0d row %0d col %0d last %0b",
        tokens_seen, want.kind.name(), want.offset, want.length, want.row, want.column,
        want.last));
      if (fail_cnt <= MAX_REPORTS)
        $display("       got kind %0d off %0d len %0d row %0d col %0d last %0b",
                 token_kind_o, start_offset_o, token_length_o, start_row_o,
                 start_column_o, last_of_run_o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: one process sees register writes, accepted input beats and
  // accepted result beats, all sampled at the same rising edge. A result can
  // never come from the beat accepted at the same edge, as descriptors are
  // registered in the queue first, so predicting before checking is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) apply_char(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_stall_o === 1'b0) predict_tokens(text_byte_i, end_of_input_i);
      if (out_valid_o === 1'b1 && !out_stall_i) check_token();
    end
  end

  // Receiver: random stall at the current rate, forced high during a hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Watchdog that fails the run if it never finishes.
  initial begin
    #20_000_000;
    $display("Timeout: %0d descriptors still owed", token_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one beat and returns in the time step of the edge that took it.
  // Valid is only dropped ahead of an idle gap, never right after acceptance.
  task automatic feed_beat(input logic [BYTE_W-1:0] b, input logic eoi);
    if (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < feed_idle_pct);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_fed++;
  endtask

  // End-of-input beat; the byte lane carries junk that must be ignored.
  task automatic feed_end();
    feed_beat(BYTE_W'($urandom_range(255)), 1'b1);
    streams_fed++;
  endtask

  // Drops valid, waits for every owed descriptor (bounded), then waits out the FLUSH_CYCLES margin.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (token_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three character registers; only called after settle().
  task automatic load_chars(input logic [BYTE_W-1:0] cmt, input logic [BYTE_W-1:0] opn,
                            input logic [BYTE_W-1:0] cls);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sts_pkg::CFG_COMMENT_CHAR;
    cfg_data_i  <= cmt;
    @(posedge clk_i);
    cfg_index_i <= sts_pkg::CFG_OPEN_CHAR;
    cfg_data_i  <= opn;
    @(posedge clk_i);
    cfg_index_i <= sts_pkg::CFG_CLOSE_CHAR;
    cfg_data_i  <= cls;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] word_byte(bit first);
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255));
    while (ends_word(b) ||
           (first && (b == sts_pkg::CH_QUOTE ||
                      (b >= sts_pkg::CH_ZERO && b <= sts_pkg::CH_NINE))));
    return b;
  endfunction

  // Byte inside a string; flipping bit 0 steers clear of newline, quote, backslash.
  function automatic logic [BYTE_W-1:0] string_byte(bit escaped);
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if (b == sts_pkg::CH_NEWLINE ||
        (!escaped && (b == sts_pkg::CH_QUOTE || b == sts_pkg::CH_BACKSLASH)))
      b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] blank_byte();
    int unsigned k;
    k = $urandom_range(5);
    // tab..CR, or space
    return (k == 5) ? sts_pkg::CH_SPACE : sts_pkg::CH_TAB + BYTE_W'(k);
  endfunction

  // Opens a string and leaves it unterminated, sometimes mid-escape.
  task automatic feed_open_string();
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 4)) feed_beat(string_byte(1'b0), 1'b0);
    if ($urandom_range(2) == 0) feed_beat(sts_pkg::CH_BACKSLASH, 1'b0);
  endtask

  // One lexical element with random content; a small share is broken or noise.
  task automatic feed_token();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 22) begin
      feed_beat(word_byte(1'b1), 1'b0);
      repeat ($urandom_range(0, 7)) feed_beat(word_byte(1'b0), 1'b0);
    end else if (pick < 36) begin
      feed_beat(sts_pkg::CH_ZERO + BYTE_W'($urandom_range(9)), 1'b0);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(3) == 0) feed_beat(word_byte(1'b0), 1'b0);
        else feed_beat(sts_pkg::CH_ZERO + BYTE_W'($urandom_range(9)), 1'b0);
      end
    end else if (pick < 50) begin
      feed_beat(sts_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(4) == 0) begin
          feed_beat(sts_pkg::CH_BACKSLASH, 1'b0);
          feed_beat(string_byte(1'b1), 1'b0);
        end else begin
          feed_beat(string_byte(1'b0), 1'b0);
        end
      end
      feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    end else if (pick < 66) begin
      feed_beat($urandom_range(1) ? open_ch : close_ch, 1'b0);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) feed_beat(blank_byte(), 1'b0);
    end else if (pick < 88) begin
      feed_beat(cmt_ch, 1'b0);
      repeat ($urandom_range(0, 6)) feed_beat(string_byte(1'b1), 1'b0);
      feed_beat(sts_pkg::CH_NEWLINE, 1'b0);
    end else if (pick < 92) begin
      feed_open_string();
      feed_beat(sts_pkg::CH_NEWLINE, 1'b0);
    end else begin
      feed_beat(BYTE_W'($urandom_range(255)), 1'b0);
    end
  endtask

  // A stream is a run of elements closed by end of input; a few end inside a
  // string or a comment.
  task automatic feed_stream();
    int unsigned tail;
    repeat ($urandom_range(2, 14)) feed_token();
    tail = $urandom_range(99);
    if (tail < 8) begin
      feed_open_string();
    end else if (tail < 12) begin
      feed_beat(cmt_ch, 1'b0);
      feed_beat(string_byte(1'b1), 1'b0);
    end
    feed_end();
  endtask

  task automatic run_mix(input int unsigned beats, input int unsigned feed_pct,
                         input int unsigned recv_pct);
    int unsigned goal;
    feed_idle_pct = feed_pct;
    stall_pct     = recv_pct;
    goal          = bytes_fed + beats;
    while (bytes_fed < goal) feed_stream();
    settle();
  endtask

  // Free-running, sender-idle, receiver-stall and both-idle stretches.
  task automatic run_all_mixes();
    run_mix(MIX_BEATS, 0, 0);
    run_mix(MIX_BEATS, 82, 0);
    run_mix(MIX_BEATS, 0, 82);
    run_mix(MIX_BEATS, 22, 22);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked bytes at reset characters: byte extremes, every token kind,
  // two-result word ends, escapes, all blanks, unclosed strings by newline,
  // by backslash-newline and by end of input, and a flush at end of input.
  task automatic test_directed_tokens();
    feed_idle_pct = 0;
    stall_pct     = 0;
    feed_beat(sts_pkg::CH_LPAREN, 1'b0);     // open
    feed_beat(8'h00, 1'b0);                  // word starting with byte 0
    feed_beat(8'hFF, 1'b0);
    feed_beat(sts_pkg::CH_RPAREN, 1'b0);     // word plus close in one beat
    feed_beat(sts_pkg::CH_ZERO + 8'd7, 1'b0);
    feed_beat(sts_pkg::CH_SEMICOLON, 1'b0);  // number ended by comment
    feed_beat(8'hFF, 1'b0);
    feed_beat(sts_pkg::CH_NEWLINE, 1'b0);
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    feed_beat(sts_pkg::CH_BACKSLASH, 1'b0);
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);      // escaped quote
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);      // string closes
    feed_beat(sts_pkg::CH_TAB, 1'b0);
    feed_beat(8'h0B, 1'b0);                  // vertical tab
    feed_beat(8'h0C, 1'b0);                  // form feed
    feed_beat(sts_pkg::CH_CR, 1'b0);
    feed_beat(sts_pkg::CH_SPACE, 1'b0);
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    feed_beat(sts_pkg::CH_BACKSLASH, 1'b0);
    feed_beat(sts_pkg::CH_NEWLINE, 1'b0);    // unclosed after backslash
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    feed_beat(sts_pkg::CH_NEWLINE, 1'b0);    // unclosed, plain newline
    feed_beat(sts_pkg::CH_QUOTE, 1'b0);
    feed_end();                              // unclosed at end, then end token
    feed_beat(sts_pkg::CH_NINE, 1'b0);
    feed_end();                              // number flushed, then end token
    settle();
  endtask

  task automatic test_idle_mixes();
    run_all_mixes();
  endtask

  // Extremes of the character registers, a bracket set, a random set and a
  // set where comment, open and close collide.
  task automatic test_char_settings();
    load_chars(8'h00, 8'hFF, 8'h01);
    run_all_mixes();
    load_chars(8'hFF, 8'h00, 8'hFE);
    run_all_mixes();
    load_chars("#", "[", "]");
    run_all_mixes();
    load_chars(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
               BYTE_W'($urandom_range(255)));
    run_all_mixes();
    load_chars(sts_pkg::CH_LPAREN, sts_pkg::CH_LPAREN, sts_pkg::CH_LPAREN);
    run_mix(MIX_BEATS, 0, 0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the result queue fills and the input stalls.
  task automatic test_back_pressure();
    load_chars(sts_pkg::CH_SEMICOLON, sts_pkg::CH_LPAREN, sts_pkg::CH_RPAREN);
    feed_idle_pct = 0;
    stall_pct     = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    repeat (8) feed_stream();
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_tokens();
    test_idle_mixes();
    test_char_settings();
    test_back_pressure();

    stall_pct = 0;
    settle();
    if (token_q.size() != 0)
      note_failure($sformatf("%0d descriptors never arrived", token_q.size()));

    $display("Fed %0d bytes in %0d streams; compared %0d token descriptors.",
             bytes_fed, streams_fed, tokens_seen);
    $display("Covered six character settings, four flow mixes and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
